// ===== rtl/json_pair_splitter_assert.svh =====
// Assertion helpers for the pair splitter; clock and reset are clk and rst.
`ifndef JSON_PAIR_SPLITTER_ASSERT_SVH
`define JSON_PAIR_SPLITTER_ASSERT_SVH

// same-cycle implication
`define JPS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define JPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/jps_pkg.sv =====
`default_nettype none

package jps_pkg;

  localparam int MAX_BRACKET_DEPTH = 15;
  localparam int DEPTH_W = $clog2(MAX_BRACKET_DEPTH + 1);

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;

  typedef enum logic [2:0] {
    EV_KEY       = 3'd0,
    EV_VALUE     = 3'd1,
    EV_COMMIT    = 3'd2,
    EV_ERR_COLON = 3'd3,
    EV_ERR_COMMA = 3'd4
  } event_kind_t;

endpackage

`default_nettype wire

// ===== rtl/json_pair_splitter.sv =====
// Channel  Dir  tdata (low bit up)                       tuser           tlast
// s        in   text_byte[7:0]                           start_of_text   -
// m        out  event_kind[2:0], char_out[10:3], 0 pad    -               message_done
//
// One character per cycle sustained while the m side accepts results; a beat
// passes the input register, then the result register behind the parser flags.
// The parser flags update when a character leaves the input register.
// rst is synchronous and clears all flags and both valid bits.
// A stalled m side holds the result; s_tready drops only when both registers
// are full and the result is not taken in that cycle.
`default_nettype none

module json_pair_splitter
  import jps_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [7:0]  s_tdata,   // text_byte[7:0]
  input  wire logic        s_tuser,   // start_of_text
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  output      logic [15:0] m_tdata,   // event_kind[2:0], char_out[10:3], zeros
  output      logic        m_tlast    // message_done
);

  // input register
  logic       in_valid;
  logic [7:0] in_char;
  logic       in_start;

  // parser state
  logic               inside_object, inside_object_next;
  logic               in_value_phase, in_value_phase_next;
  logic               inside_quote, inside_quote_next;
  logic [DEPTH_W-1:0] nest_depth, nest_depth_next;
  logic               inside_brace, inside_brace_next;
  logic               value_empty, value_empty_next;
  logic               finished, finished_next;

  // result register
  logic        out_valid;
  event_kind_t out_kind;
  logic [7:0]  out_char;
  logic        out_done;

  logic        step;
  logic        res_valid;
  event_kind_t res_kind;
  logic [7:0]  res_char;
  logic        res_done;

  assign step     = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || step;

  always_comb begin
    logic               obj, valph, quote, brace, vempty, fin, top;
    logic [DEPTH_W-1:0] depth;
    obj    = inside_object;
    valph  = in_value_phase;
    quote  = inside_quote;
    depth  = nest_depth;
    brace  = inside_brace;
    vempty = value_empty;
    fin    = finished;
    if (in_start) begin
      obj    = 1'b0;
      valph  = 1'b0;
      quote  = 1'b0;
      depth  = '0;
      brace  = 1'b0;
      vempty = 1'b1;
      fin    = 1'b0;
    end

    inside_object_next  = obj;
    in_value_phase_next = valph;
    inside_quote_next   = quote;
    nest_depth_next     = depth;
    inside_brace_next   = brace;
    value_empty_next    = vempty;
    finished_next       = fin;
    res_valid = 1'b0;
    res_kind  = EV_KEY;
    res_char  = 8'd0;
    res_done  = 1'b0;

    top = !quote && (depth == '0) && !brace;

    if (fin) begin
      // ignored until the next start flag
    end else if (!obj) begin
      if (in_char == CH_LBRACE) begin
        inside_object_next  = 1'b1;
        in_value_phase_next = 1'b0;
      end
    end else if (in_char == CH_RBRACE && top) begin
      inside_object_next  = 1'b0;
      in_value_phase_next = 1'b0;
      value_empty_next    = 1'b1;
      finished_next       = 1'b1;
      res_valid = 1'b1;
      res_kind  = EV_COMMIT;
      res_done  = 1'b1;
    end else if (in_char == CH_COLON && top) begin
      if (valph) begin
        finished_next = 1'b1;
        res_valid = 1'b1;
        res_kind  = EV_ERR_COLON;
        res_done  = 1'b1;
      end else begin
        in_value_phase_next = 1'b1;
      end
    end else if (in_char == CH_LBRACK && !quote && valph && !brace) begin
      // saturating depth; only the outermost bracket is stripped
      if (depth != DEPTH_W'(MAX_BRACKET_DEPTH)) begin
        nest_depth_next = depth + 1'b1;
      end
      if (nest_depth_next > DEPTH_W'(1)) begin
        value_empty_next = 1'b0;
        res_valid = 1'b1;
        res_kind  = EV_VALUE;
        res_char  = in_char;
      end
    end else if (in_char == CH_RBRACK && !quote && valph && depth != '0 && !brace) begin
      nest_depth_next = depth - 1'b1;
      if (nest_depth_next != '0) begin
        value_empty_next = 1'b0;
        res_valid = 1'b1;
        res_kind  = EV_VALUE;
        res_char  = in_char;
      end
    end else if (in_char == CH_LBRACE && !quote && valph && depth == '0 && !brace
                 && vempty) begin
      inside_brace_next = 1'b1;
    end else if (in_char == CH_RBRACE && !quote && valph && brace && depth == '0) begin
      inside_brace_next = 1'b0;
    end else if (in_char == CH_COMMA && top) begin
      if (!valph) begin
        finished_next = 1'b1;
        res_valid = 1'b1;
        res_kind  = EV_ERR_COMMA;
        res_done  = 1'b1;
      end else begin
        in_value_phase_next = 1'b0;
        value_empty_next    = 1'b1;
        res_valid = 1'b1;
        res_kind  = EV_COMMIT;
      end
    end else if (in_char == CH_QUOTE && depth == '0 && !brace) begin
      inside_quote_next = !quote;
    end else if (valph) begin
      value_empty_next = 1'b0;
      res_valid = 1'b1;
      res_kind  = EV_VALUE;
      res_char  = in_char;
    end else begin
      res_valid = 1'b1;
      res_kind  = EV_KEY;
      res_char  = in_char;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid       <= 1'b0;
      out_valid      <= 1'b0;
      inside_object  <= 1'b0;
      in_value_phase <= 1'b0;
      inside_quote   <= 1'b0;
      nest_depth     <= '0;
      inside_brace   <= 1'b0;
      value_empty    <= 1'b1;
      finished       <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
      end else if (step) begin
        in_valid <= 1'b0;
      end

      if (step) begin
        inside_object  <= inside_object_next;
        in_value_phase <= in_value_phase_next;
        inside_quote   <= inside_quote_next;
        nest_depth     <= nest_depth_next;
        inside_brace   <= inside_brace_next;
        value_empty    <= value_empty_next;
        finished       <= finished_next;
      end

      if (step) begin
        out_valid <= res_valid;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_char  <= s_tdata;
      in_start <= s_tuser;
    end
    if (step) begin
      out_kind <= res_kind;
      out_char <= res_char;
      out_done <= res_done;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'd0, out_char, out_kind};
  assign m_tlast  = out_done;

`include "json_pair_splitter_assert.svh"

  `JPS_ASSERT_NOW(a_done_sets_finished, m_tvalid && m_tlast, finished, "done beat without finished flag")
  `JPS_ASSERT_NOW(a_char_only_for_text, m_tvalid && (out_kind != EV_KEY) && (out_kind != EV_VALUE), out_char == 8'd0, "nonzero char on control event")
  `JPS_ASSERT_NOW(a_brace_in_value, inside_brace || (nest_depth != '0), in_value_phase, "nesting outside value phase")
  `JPS_ASSERT_NEXT(a_stall_holds_result, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result changed")

endmodule

`default_nettype wire
